>>> sv/psr_pkg.sv
`default_nettype none

package psr_pkg;

  // Default sizes, handed to the top level parameters
  localparam int MAX_TAPS_DEF    = 64;
  localparam int PHASES_HALF_DEF = 32;

  // Most outputs produced per input sample
  localparam int MAX_RESULTS = 16;

  // Result queue depth
  localparam int OUTQ_DEPTH = 4;

  // Field widths
  localparam int SAMPLE_W = 24;
  localparam int COEF_W   = 18;
  localparam int PHASE_W  = 7;
  localparam int TAP_W    = 6;
  localparam int STEP_W   = 21;
  localparam int TAPS_W   = 7;
  localparam int TIME_W   = 32;
  localparam int PROD_W   = SAMPLE_W + COEF_W;

  // Q16.16 constants
  localparam int ONE_Q16  = 65536;
  localparam int HALF_Q16 = 32768;

  // Output limits, Q1.23
  localparam int OUT_MAX = 8388607;
  localparam int OUT_MIN = -8388608;

  // Reset values of the configuration registers
  localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(65536);
  localparam logic [TAPS_W-1:0] TAPS_RESET = TAPS_W'(64);

  // Configuration register indexes
  localparam logic CFG_STEP_RATIO  = 1'b0;
  localparam logic CFG_TAPS_IN_USE = 1'b1;

  typedef enum logic {
    CMD_COEF   = 1'b0,
    CMD_SAMPLE = 1'b1
  } cmd_kind_e;

  // One classified beat passed from front to back
  typedef struct packed {
    cmd_kind_e                  kind;
    logic signed [SAMPLE_W-1:0] sample;
    logic [PHASE_W-1:0]         phase;
    logic [TAP_W-1:0]           tap;
    logic signed [COEF_W-1:0]   value;
  } cmd_t;

  // One result beat
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       last;
  } res_t;

  // Configuration write
  typedef struct packed {
    logic               valid;
    logic               index;
    logic [STEP_W-1:0]  data;
  } cfg_wr_t;

endpackage

`default_nettype wire

>>> sv/psr_front.sv
`default_nettype none

module psr_front #(
  parameter int MAX_TAPS    = psr_pkg::MAX_TAPS_DEF,
  parameter int PHASES_HALF = psr_pkg::PHASES_HALF_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               push_i,
  output logic                               full_o,
  input  logic                               func_i,
  input  logic signed [psr_pkg::SAMPLE_W-1:0] sample_in_i,
  input  logic [psr_pkg::PHASE_W-1:0]        coef_phase_i,
  input  logic [psr_pkg::TAP_W-1:0]          coef_tap_i,
  input  logic signed [psr_pkg::COEF_W-1:0]  coef_value_i,
  output logic                               cmd_valid_o,
  output psr_pkg::cmd_t                      cmd_o,
  input  logic                               cmd_pop_i
);
  import psr_pkg::*;

  localparam int ROWS = 2 * PHASES_HALF + 1;

  cmd_t       q_mem [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       coef_ok;
  logic       accept;
  logic       keep;
  cmd_t       cmd_new;

  // Coefficient beats outside the table are taken and dropped here
  assign coef_ok = (32'(coef_phase_i) < 32'(ROWS)) && (32'(coef_tap_i) < 32'(MAX_TAPS));
  assign full_o  = (cnt_q == 2'd2);
  assign accept  = push_i && !full_o;
  assign keep    = accept && ((func_i == CMD_SAMPLE) || coef_ok);

  always_comb begin
    cmd_new.kind   = cmd_kind_e'(func_i);
    cmd_new.sample = sample_in_i;
    cmd_new.phase  = coef_phase_i;
    cmd_new.tap    = coef_tap_i;
    cmd_new.value  = coef_value_i;
  end

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (keep) begin
      wr_ptr_d = ~wr_ptr_q;
    end
    if (cmd_pop_i) begin
      rd_ptr_d = ~rd_ptr_q;
    end
    case ({keep, cmd_pop_i})
      2'b10:   cnt_d = cnt_q + 2'd1;
      2'b01:   cnt_d = cnt_q - 2'd1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (keep) begin
      q_mem[wr_ptr_q] <= cmd_new;
    end
  end

  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = q_mem[rd_ptr_q];

endmodule

`default_nettype wire

>>> sv/psr_outq.sv
`default_nettype none

module psr_outq (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  psr_pkg::res_t data_i,
  output logic          full_o,
  output logic          empty_o,
  input  logic          pop_i,
  output psr_pkg::res_t data_o
);
  import psr_pkg::*;

  localparam int PTR_W = $clog2(OUTQ_DEPTH);
  localparam int CNT_W = $clog2(OUTQ_DEPTH + 1);

  res_t             mem [OUTQ_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             do_wr;
  logic             do_rd;

  assign full_o  = (32'(cnt_q) == OUTQ_DEPTH);
  assign empty_o = (cnt_q == '0);
  assign do_wr   = push_i && !full_o;
  assign do_rd   = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (do_wr) begin
      wr_ptr_d = (32'(wr_ptr_q) == OUTQ_DEPTH - 1) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (do_rd) begin
      rd_ptr_d = (32'(rd_ptr_q) == OUTQ_DEPTH - 1) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    case ({do_wr, do_rd})
      2'b10:   cnt_d = cnt_q + CNT_W'(1);
      2'b01:   cnt_d = cnt_q - CNT_W'(1);
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem[wr_ptr_q] <= data_i;
    end
  end

  assign data_o = mem[rd_ptr_q];

endmodule

`default_nettype wire

>>> sv/psr_back.sv
`default_nettype none

module psr_back #(
  parameter int MAX_TAPS    = psr_pkg::MAX_TAPS_DEF,
  parameter int PHASES_HALF = psr_pkg::PHASES_HALF_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  psr_pkg::cfg_wr_t cfg_i,
  input  logic             cmd_valid_i,
  input  psr_pkg::cmd_t    cmd_i,
  output logic             cmd_pop_o,
  output logic             res_push_o,
  output psr_pkg::res_t    res_o,
  input  logic             res_full_i
);
  import psr_pkg::*;

  localparam int ROWS    = 2 * PHASES_HALF + 1;
  localparam int PH2     = 2 * PHASES_HALF;
  localparam int CADDR_W = $clog2(ROWS * MAX_TAPS);
  localparam int HADDR_W = $clog2(MAX_TAPS);
  localparam int FILL_W  = $clog2(MAX_TAPS + 1);
  localparam int ROW_W   = $clog2(ROWS);
  localparam int ACC_W   = PROD_W + $clog2(MAX_TAPS);
  localparam int RND_W   = ACC_W - 16;
  localparam int R_W     = 18;
  localparam int CNT_W   = $clog2(MAX_RESULTS + 1);
  localparam int FR_W    = 26;

  localparam logic signed [TIME_W-1:0] TIME_FLOOR = TIME_W'(-(MAX_TAPS + 4) * ONE_Q16);
  localparam logic signed [TIME_W-1:0] TIME_ONE   = TIME_W'(ONE_Q16);
  localparam logic signed [TIME_W-1:0] TIME_BIAS  = TIME_W'(ONE_Q16 + HALF_Q16);
  localparam logic signed [RND_W-1:0]  SAT_HI     = RND_W'(OUT_MAX);
  localparam logic signed [RND_W-1:0]  SAT_LO     = RND_W'(OUT_MIN);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_CALC  = 3'd1;
  localparam logic [2:0] ST_CHECK = 3'd2;
  localparam logic [2:0] ST_BASE  = 3'd3;
  localparam logic [2:0] ST_MAC   = 3'd4;
  localparam logic [2:0] ST_DRAIN = 3'd5;
  localparam logic [2:0] ST_ROUND = 3'd6;
  localparam logic [2:0] ST_SAT   = 3'd7;

  // Storage
  logic signed [COEF_W-1:0]   coef_mem [ROWS * MAX_TAPS];
  logic signed [SAMPLE_W-1:0] hist_mem [MAX_TAPS];

  // Control and datapath registers
  logic [2:0]                 state_q, state_d;
  logic [STEP_W-1:0]          step_q, step_d;
  logic [TAPS_W-1:0]          taps_q, taps_d;
  logic signed [TIME_W-1:0]   tp_q, tp_d;
  logic [FILL_W-1:0]          fill_q, fill_d;
  logic [HADDR_W-1:0]         wp_q, wp_d;
  logic [CNT_W-1:0]           cnt_q, cnt_d;
  logic                       pend_q, pend_d;
  logic [HADDR_W-1:0]         tap_q, tap_d;
  logic signed [TIME_W-1:0]   x_q, x_d;
  logic [ROW_W-1:0]           row_q, row_d;
  logic signed [R_W-1:0]      r_q, r_d;
  logic [CADDR_W-1:0]         base_q, base_d;
  logic signed [RND_W-1:0]    rnd_q, rnd_d;
  logic signed [SAMPLE_W-1:0] res_q, res_d;

  // MAC pipeline
  logic                       p1_valid_q, p1_ok_q, p2_valid_q;
  logic signed [COEF_W-1:0]   coef_rd_q;
  logic signed [SAMPLE_W-1:0] hist_rd_q;
  logic signed [PROD_W-1:0]   prod_w;
  logic signed [PROD_W-1:0]   prod_q;
  logic signed [ACC_W-1:0]    acc_q;

  // Combinational helpers
  logic [FILL_W-1:0]          len;
  logic [FILL_W-1:0]          h;
  logic signed [15:0]         s_w;
  logic signed [R_W-1:0]      s_plus_h;
  logic                       brk;
  logic [FR_W-1:0]            frac_prod;
  logic [FR_W-17:0]           row_raw;
  logic signed [TIME_W-1:0]   tp_dec;
  logic [HADDR_W-1:0]         wp_next;
  logic                       tap_ok;
  logic [HADDR_W-1:0]         rr;
  logic [HADDR_W-1:0]         haddr;
  logic [CADDR_W-1:0]         caddr;
  logic                       coef_we;
  logic [CADDR_W-1:0]         coef_waddr;
  logic                       hist_we;
  logic signed [ACC_W-1:0]    acc_rnd;

  // Filter length clipped to 2..MAX_TAPS
  always_comb begin
    if (taps_q < TAPS_W'(2)) begin
      len = FILL_W'(2);
    end else if (32'(taps_q) > MAX_TAPS) begin
      len = FILL_W'(MAX_TAPS);
    end else begin
      len = FILL_W'(taps_q);
    end
  end
  assign h = len - FILL_W'(1);

  // Window start and phase row, from x = t + 1 + 1/2 - h/2
  assign s_w       = x_q[TIME_W-1:16];
  assign s_plus_h  = R_W'(s_w) + $signed(R_W'(h));
  assign brk       = (s_plus_h > 0) || (32'(cnt_q) == MAX_RESULTS);
  assign frac_prod = FR_W'(x_q[15:0]) * FR_W'(PH2) + FR_W'(HALF_Q16);
  assign row_raw   = frac_prod[FR_W-1:16];

  assign tp_dec  = tp_q - TIME_ONE;
  assign wp_next = (32'(wp_q) == MAX_TAPS - 1) ? '0 : wp_q + HADDR_W'(1);

  // History tap r back from the newest; older than the fill reads as zero
  assign tap_ok = (r_q < $signed(R_W'(fill_q)));
  assign rr     = r_q[HADDR_W-1:0];
  assign haddr  = (wp_q >= rr) ? wp_q - rr : HADDR_W'(32'(wp_q) + MAX_TAPS - 32'(rr));
  assign caddr  = base_q + CADDR_W'(tap_q);

  assign coef_waddr = CADDR_W'(32'(cmd_i.phase) * MAX_TAPS + 32'(cmd_i.tap));
  assign acc_rnd    = acc_q + $signed(ACC_W'(HALF_Q16));

  always_comb begin
    state_d    = state_q;
    step_d     = step_q;
    taps_d     = taps_q;
    tp_d       = tp_q;
    fill_d     = fill_q;
    wp_d       = wp_q;
    cnt_d      = cnt_q;
    pend_d     = pend_q;
    tap_d      = tap_q;
    x_d        = x_q;
    row_d      = row_q;
    r_d        = r_q;
    base_d     = base_q;
    rnd_d      = rnd_q;
    res_d      = res_q;
    cmd_pop_o  = 1'b0;
    res_push_o = 1'b0;
    res_o.sample = res_q;
    res_o.last   = brk;
    coef_we    = 1'b0;
    hist_we    = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          if (cmd_i.kind == CMD_SAMPLE) begin
            hist_we = 1'b1;
            wp_d    = wp_next;
            if (32'(fill_q) < MAX_TAPS) begin
              fill_d = fill_q + FILL_W'(1);
            end
            tp_d    = (tp_dec < TIME_FLOOR) ? TIME_FLOOR : tp_dec;
            cnt_d   = '0;
            pend_d  = 1'b0;
            state_d = ST_CALC;
          end else begin
            coef_we = 1'b1;
          end
        end
      end
      ST_CALC: begin
        x_d     = tp_q + TIME_BIAS - $signed(TIME_W'(h) << 15);
        state_d = ST_CHECK;
      end
      ST_CHECK: begin
        // The previous result leaves here once we know whether it ends the run
        if (!(pend_q && res_full_i)) begin
          if (pend_q) begin
            res_push_o = 1'b1;
            pend_d     = 1'b0;
          end
          if (brk) begin
            state_d = ST_IDLE;
          end else begin
            row_d   = (32'(row_raw) > PH2) ? ROW_W'(PH2) : ROW_W'(row_raw);
            r_d     = -R_W'(s_w);
            state_d = ST_BASE;
          end
        end
      end
      ST_BASE: begin
        base_d  = CADDR_W'(32'(row_q) * MAX_TAPS);
        tap_d   = '0;
        state_d = ST_MAC;
      end
      ST_MAC: begin
        tap_d = tap_q + HADDR_W'(1);
        r_d   = r_q - R_W'(1);
        if (tap_q == HADDR_W'(h)) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!p1_valid_q && !p2_valid_q) begin
          state_d = ST_ROUND;
        end
      end
      ST_ROUND: begin
        rnd_d   = acc_rnd[ACC_W-1:16];
        tp_d    = tp_q + $signed(TIME_W'(step_q));
        cnt_d   = cnt_q + CNT_W'(1);
        state_d = ST_SAT;
      end
      ST_SAT: begin
        if (rnd_q > SAT_HI) begin
          res_d = SAMPLE_W'(OUT_MAX);
        end else if (rnd_q < SAT_LO) begin
          res_d = SAMPLE_W'(OUT_MIN);
        end else begin
          res_d = rnd_q[SAMPLE_W-1:0];
        end
        pend_d  = 1'b1;
        state_d = ST_CALC;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // The user must send config beats only while idle; the block does not enforce it. A new ratio restarts the filter
    if (cfg_i.valid) begin
      if (cfg_i.index == CFG_STEP_RATIO) begin
        if (cfg_i.data != step_q) begin
          fill_d = '0;
          tp_d   = '0;
        end
        step_d = cfg_i.data;
      end else begin
        taps_d = cfg_i.data[TAPS_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      step_q     <= STEP_RESET;
      taps_q     <= TAPS_RESET;
      tp_q       <= '0;
      fill_q     <= '0;
      wp_q       <= '0;
      cnt_q      <= '0;
      pend_q     <= 1'b0;
      tap_q      <= '0;
      p1_valid_q <= 1'b0;
      p2_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      step_q     <= step_d;
      taps_q     <= taps_d;
      tp_q       <= tp_d;
      fill_q     <= fill_d;
      wp_q       <= wp_d;
      cnt_q      <= cnt_d;
      pend_q     <= pend_d;
      tap_q      <= tap_d;
      p1_valid_q <= (state_q == ST_MAC);
      p2_valid_q <= p1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q     <= x_d;
    row_q   <= row_d;
    r_q     <= r_d;
    base_q  <= base_d;
    rnd_q   <= rnd_d;
    res_q   <= res_d;
    p1_ok_q <= tap_ok;
  end

  // Coefficient table
  always_ff @(posedge clk_i) begin
    if (coef_we) begin
      coef_mem[coef_waddr] <= cmd_i.value;
    end
    coef_rd_q <= coef_mem[caddr];
  end

  // Sample history ring
  always_ff @(posedge clk_i) begin
    if (hist_we) begin
      hist_mem[wp_next] <= cmd_i.sample;
    end
    hist_rd_q <= hist_mem[haddr];
  end

  // Multiply, then accumulate
  assign prod_w = hist_rd_q * coef_rd_q;

  always_ff @(posedge clk_i) begin
    prod_q <= p1_ok_q ? prod_w : '0;
    if (state_q == ST_BASE) begin
      acc_q <= '0;
    end else if (p2_valid_q) begin
      acc_q <= acc_q + ACC_W'(prod_q);
    end
  end

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(fill_q) <= MAX_TAPS)
    else $error("history fill beyond depth");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(cnt_q) <= MAX_RESULTS)
    else $error("too many results for one sample");

  a_time_floor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CALC) |-> (tp_q >= TIME_FLOOR))
    else $error("output time below floor");

  a_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ROUND) |-> (!p1_valid_q && !p2_valid_q))
    else $error("rounding before MAC pipeline drained");

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push_o |-> (!res_full_i && pend_q && (state_q == ST_CHECK)))
    else $error("result pushed into full queue");

endmodule

`default_nettype wire

>>> sv/polyphase_sinc_resampler.sv
// Polyphase windowed-sinc sample-rate converter.
// Input channel (push/full): a beat with func_i=1 pushes one Q1.23 sample
// into the tap history; func_i=0 loads one Q2.16 coefficient at
// (coef_phase_i, coef_tap_i). Addresses outside the table are taken and dropped.
// Result channel (empty/pop): each beat is one Q1.23 output; last_o marks the
// final output raised by a given input sample (at most 16 per sample).
// Config channel (cfg_valid_i/cfg_ready_o): index 0 step_ratio (unsigned Q5.16),
// index 1 taps_in_use. Always ready. A changed step_ratio empties the history
// and zeroes the output time. Write only while the block is idle.
// Timing: a two-beat front queue takes input while the back end works. Each
// output is computed by the single shared multiply-accumulate unit stepping
// one tap per cycle over the L clipped taps; a sample beat starts a run of
// outputs, while a coefficient beat only writes the table.
// A finished output is held until the next check decides whether it ends the run.
// A four-beat result queue decouples the consumer; once it is full the back
// end holds the finished output, the front queue fills and full rises.
// Reset: history empty (reads as zero), output time zero, step_ratio 65536,
// taps_in_use 64. The coefficient table holds no defined value until loaded.
`default_nettype none

module polyphase_sinc_resampler #(
  parameter int MAX_TAPS    = psr_pkg::MAX_TAPS_DEF,
  parameter int PHASES_HALF = psr_pkg::PHASES_HALF_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // input queue side
  input  logic                               push,
  output logic                               full,
  input  logic                               func_i,
  input  logic signed [psr_pkg::SAMPLE_W-1:0] sample_in_i,
  input  logic [psr_pkg::PHASE_W-1:0]        coef_phase_i,
  input  logic [psr_pkg::TAP_W-1:0]          coef_tap_i,
  input  logic signed [psr_pkg::COEF_W-1:0]  coef_value_i,
  // result queue side
  output logic                               empty,
  input  logic                               pop,
  output logic signed [psr_pkg::SAMPLE_W-1:0] sample_out_o,
  output logic                               last_o,
  // configuration writes
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic                               cfg_index_i,
  input  logic [psr_pkg::STEP_W-1:0]         cfg_data_i
);
  import psr_pkg::*;

  cmd_t    cmd;
  logic    cmd_valid;
  logic    cmd_pop;
  res_t    res_in;
  res_t    res_out;
  logic    res_push;
  logic    res_full;
  cfg_wr_t cfg;

  // Config is never back-pressured
  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg.valid = cfg_valid_i;
    cfg.index = cfg_index_i;
    cfg.data  = cfg_data_i;
  end

  // Front: takes beats, drops bad coefficient addresses, queues the rest
  psr_front #(
    .MAX_TAPS    (MAX_TAPS),
    .PHASES_HALF (PHASES_HALF)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .full_o       (full),
    .func_i       (func_i),
    .sample_in_i  (sample_in_i),
    .coef_phase_i (coef_phase_i),
    .coef_tap_i   (coef_tap_i),
    .coef_value_i (coef_value_i),
    .cmd_valid_o  (cmd_valid),
    .cmd_o        (cmd),
    .cmd_pop_i    (cmd_pop)
  );

  // Back: history, coefficient table, output timing and the MAC
  psr_back #(
    .MAX_TAPS    (MAX_TAPS),
    .PHASES_HALF (PHASES_HALF)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .res_push_o  (res_push),
    .res_o       (res_in),
    .res_full_i  (res_full)
  );

  // Result queue towards the consumer
  psr_outq u_outq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res_in),
    .full_o  (res_full),
    .empty_o (empty),
    .pop_i   (pop),
    .data_o  (res_out)
  );

  assign sample_out_o = res_out.sample;
  assign last_o       = res_out.last;

endmodule

`default_nettype wire
